// ===== hw/rtl/pnf_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pnf_pkg - shared types, constants and functions of the fBm noise pixel block
// Widths, register codes, gradient codes and the fixed-point dot and lerp.
// ---------------------------------------------------------------------------
package pnf_pkg;

   localparam int unsigned TABLE_ENTRIES_DEF = 256;
   localparam int unsigned MAX_OCTAVES_DEF   = 8;
   localparam int unsigned COORD_BITS_DEF    = 16;

   localparam int unsigned FREQ_W    = 24;
   localparam int unsigned OCT_CNT_W = 4;
   localparam int unsigned PERM_W    = 8;
   localparam int unsigned PIX_W     = 16;
   localparam int unsigned FRAC_W    = 16;
   localparam int unsigned FADE_W    = 17;
   localparam int unsigned VAL_W     = 20;
   localparam int unsigned NOISE_W   = 8;
   localparam int unsigned REQ_W     = 48;
   localparam int unsigned CSR_IDX_W = 1;

   localparam logic [FREQ_W-1:0]    FREQ_RESET = 24'd83886;
   localparam logic [OCT_CNT_W-1:0] OCT_RESET  = 4'd8;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASE_FREQ = 1'b0,
      CSR_OCT_COUNT = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      GRAD_PP = 2'd0,
      GRAD_MP = 2'd1,
      GRAD_MM = 2'd2,
      GRAD_PM = 2'd3
   } grad_type;

   typedef struct packed {
      logic              valid;
      logic              pixel;
      logic [PERM_W-1:0] index;
      logic [PERM_W-1:0] value;
   } pnf_ctl_type;

   typedef logic signed [VAL_W-1:0] val_type;

   localparam val_type ONE_Q16 = 20'sd65536;

   function automatic val_type grad_dot(grad_type g, logic [FRAC_W-1:0] tx,
                                        logic [FRAC_W-1:0] ty, logic x_next,
                                        logic y_next);
      val_type dx;
      val_type dy;
      val_type r;
      dx = $signed({4'b0, tx}) - (x_next ? ONE_Q16 : 20'sd0);
      dy = $signed({4'b0, ty}) - (y_next ? ONE_Q16 : 20'sd0);
      unique case (g)
         GRAD_PP: r = dx + dy;
         GRAD_MP: r = dy - dx;
         GRAD_MM: r = -dx - dy;
         GRAD_PM: r = dx - dy;
         default: r = dx - dy;
      endcase
      return r;
   endfunction

   // a + floor((f*(b-a) + 2^15) / 2^16)
   function automatic val_type lerp(logic [FADE_W-1:0] f, val_type a, val_type b);
      logic signed [VAL_W:0]          d;
      logic signed [VAL_W+FADE_W+1:0] p;
      d = $signed({b[VAL_W-1], b}) - $signed({a[VAL_W-1], a});
      p = $signed({1'b0, f}) * d;
      p = p + 39'sd32768;
      return a + $signed(p[VAL_W+15:16]);
   endfunction

endpackage

// ===== hw/rtl/pnf_fade.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pnf_fade - quintic fade 6t^5-15t^4+10t^3, Q0.16 in, Q1.16 out
// Three register stages: square, cube and polynomial, final product.
// ---------------------------------------------------------------------------
module pnf_fade (
   input  logic                        clock,
   input  logic                        adv,
   input  logic [pnf_pkg::FRAC_W-1:0]  t,
   output logic [pnf_pkg::FADE_W-1:0]  f
);

   logic [15:0] t_ff;
   logic [31:0] t2_ff;
   logic [31:0] t3h_ff;
   logic [19:0] qh_ff;
   logic [16:0] f_ff;

   logic [47:0] t3_in;
   logic [39:0] q_in;
   logic [51:0] p_in;
   logic [16:0] f_in;

   always_comb begin
      t3_in = 48'(t2_ff) * 48'(t_ff);
      q_in  = (40'd10 << 32) - ((40'(t_ff) * 40'd15) << 16) + 40'(t2_ff) * 40'd6;
      p_in  = 52'(t3h_ff) * 52'(qh_ff) + (52'd1 << 31);
      f_in  = (p_in[51:32] > 20'd65536) ? 17'd65536 : p_in[48:32];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t_ff    <= t;
         t2_ff   <= 32'(t) * 32'(t);
         t3h_ff  <= t3_in[47:16];
         qh_ff   <= q_in[35:16];
         f_ff    <= f_in;
      end
   end

   assign f = f_ff;

endmodule

// ===== hw/rtl/pnf_octave.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pnf_octave - one octave of 2D gradient noise
// Lattice split, two-level hash through local table copies, dots, fades and
// bilinear interpolation over stages two to six.
// ---------------------------------------------------------------------------
module pnf_octave #(
   parameter int unsigned TABLE_ENTRIES = pnf_pkg::TABLE_ENTRIES_DEF,
   parameter int unsigned COORD_BITS    = pnf_pkg::COORD_BITS_DEF,
   parameter int unsigned OCTAVE        = 0
) (
   input  logic                                     clock,
   input  logic                                     adv,
   input  pnf_pkg::pnf_ctl_type                     ctl1,
   input  pnf_pkg::pnf_ctl_type                     ctl2,
   input  logic [COORD_BITS+pnf_pkg::FREQ_W-1:0]    mul_x,
   input  logic [COORD_BITS+pnf_pkg::FREQ_W-1:0]    mul_y,
   output pnf_pkg::val_type                         noise
);

   localparam int unsigned IDX_W  = $clog2(TABLE_ENTRIES);
   localparam int unsigned MUL_W  = COORD_BITS + pnf_pkg::FREQ_W;
   localparam int unsigned WIDE_W = MUL_W + OCTAVE;

   logic [pnf_pkg::PERM_W-1:0] perm_a_mem [TABLE_ENTRIES];
   logic [1:0]                 grad_b_mem [TABLE_ENTRIES];
   logic [1:0]                 grad_c_mem [TABLE_ENTRIES];

   logic [WIDE_W-1:0] wx;
   logic [WIDE_W-1:0] wy;
   logic [IDX_W-1:0]  xu;
   logic [IDX_W-1:0]  xn;
   logic [IDX_W-1:0]  yu;
   logic [pnf_pkg::FRAC_W-1:0] tx;
   logic [pnf_pkg::FRAC_W-1:0] ty;
   logic we_a;
   logic we_b;

   logic [pnf_pkg::PERM_W-1:0] ha_ff;
   logic [pnf_pkg::PERM_W-1:0] hb_ff;
   logic [IDX_W-1:0]           yu_ff;
   logic [IDX_W-1:0]           yn_ff;
   logic [pnf_pkg::FRAC_W-1:0] tx2_ff;
   logic [pnf_pkg::FRAC_W-1:0] ty2_ff;

   logic [IDX_W-1:0] a0_in;
   logic [IDX_W-1:0] a1_in;
   logic [IDX_W-1:0] b0_in;
   logic [IDX_W-1:0] b1_in;

   logic [1:0]                 g_bl_ff;
   logic [1:0]                 g_tl_ff;
   logic [1:0]                 g_br_ff;
   logic [1:0]                 g_tr_ff;
   logic [pnf_pkg::FRAC_W-1:0] tx3_ff;
   logic [pnf_pkg::FRAC_W-1:0] ty3_ff;

   pnf_pkg::val_type dot_bl_ff;
   pnf_pkg::val_type dot_br_ff;
   pnf_pkg::val_type dot_tl_ff;
   pnf_pkg::val_type dot_tr_ff;

   logic [pnf_pkg::FADE_W-1:0] fx;
   logic [pnf_pkg::FADE_W-1:0] fy;
   logic [pnf_pkg::FADE_W-1:0] fx5_ff;
   pnf_pkg::val_type           ly0_ff;
   pnf_pkg::val_type           ly1_ff;
   pnf_pkg::val_type           n_ff;

   always_comb begin
      wx   = WIDE_W'(mul_x) << OCTAVE;
      wy   = WIDE_W'(mul_y) << OCTAVE;
      xu   = wx[24 +: IDX_W];
      yu   = wy[24 +: IDX_W];
      xn   = xu + 1'b1;
      tx   = wx[8 +: pnf_pkg::FRAC_W];
      ty   = wy[8 +: pnf_pkg::FRAC_W];
      we_a = adv && ctl1.valid && !ctl1.pixel && (9'(ctl1.index) < 9'(TABLE_ENTRIES));
      we_b = adv && ctl2.valid && !ctl2.pixel && (9'(ctl2.index) < 9'(TABLE_ENTRIES));
      a0_in = IDX_W'(ha_ff) + yu_ff;
      a1_in = IDX_W'(ha_ff) + yn_ff;
      b0_in = IDX_W'(hb_ff) + yu_ff;
      b1_in = IDX_W'(hb_ff) + yn_ff;
   end

   always_ff @(posedge clock) begin
      if (we_a) begin
         perm_a_mem[ctl1.index[IDX_W-1:0]] <= ctl1.value;
      end
      if (we_b) begin
         grad_b_mem[ctl2.index[IDX_W-1:0]] <= ctl2.value[1:0];
         grad_c_mem[ctl2.index[IDX_W-1:0]] <= ctl2.value[1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ha_ff  <= perm_a_mem[xu];
         hb_ff  <= perm_a_mem[xn];
         yu_ff  <= yu;
         yn_ff  <= yu + 1'b1;
         tx2_ff <= tx;
         ty2_ff <= ty;

         g_bl_ff <= grad_b_mem[a0_in];
         g_tl_ff <= grad_b_mem[a1_in];
         g_br_ff <= grad_c_mem[b0_in];
         g_tr_ff <= grad_c_mem[b1_in];
         tx3_ff  <= tx2_ff;
         ty3_ff  <= ty2_ff;

         dot_bl_ff <= pnf_pkg::grad_dot(pnf_pkg::grad_type'(g_bl_ff), tx3_ff, ty3_ff,
                                        1'b0, 1'b0);
         dot_br_ff <= pnf_pkg::grad_dot(pnf_pkg::grad_type'(g_br_ff), tx3_ff, ty3_ff,
                                        1'b1, 1'b0);
         dot_tl_ff <= pnf_pkg::grad_dot(pnf_pkg::grad_type'(g_tl_ff), tx3_ff, ty3_ff,
                                        1'b0, 1'b1);
         dot_tr_ff <= pnf_pkg::grad_dot(pnf_pkg::grad_type'(g_tr_ff), tx3_ff, ty3_ff,
                                        1'b1, 1'b1);

         ly0_ff <= pnf_pkg::lerp(fy, dot_bl_ff, dot_tl_ff);
         ly1_ff <= pnf_pkg::lerp(fy, dot_br_ff, dot_tr_ff);
         fx5_ff <= fx;

         n_ff <= pnf_pkg::lerp(fx5_ff, ly0_ff, ly1_ff);
      end
   end

   pnf_fade u_fade_x (
      .clock (clock),
      .adv   (adv),
      .t     (tx),
      .f     (fx)
   );

   pnf_fade u_fade_y (
      .clock (clock),
      .adv   (adv),
      .t     (ty),
      .f     (fy)
   );

   assign noise = n_ff;

endmodule

// ===== hw/rtl/pnf_sum.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pnf_sum - weighted octave sum and mapping to 0..255
// Pair sums, total, then round((s+1)/2*255) with saturation.
// ---------------------------------------------------------------------------
module pnf_sum #(
   parameter int unsigned MAX_OCTAVES = pnf_pkg::MAX_OCTAVES_DEF
) (
   input  logic                                clock,
   input  logic                                adv,
   input  logic [$clog2(MAX_OCTAVES+1)-1:0]    oct_eff,
   input  pnf_pkg::val_type                    noise [MAX_OCTAVES],
   output logic [pnf_pkg::NOISE_W-1:0]         value
);

   localparam int unsigned OCT_W  = $clog2(MAX_OCTAVES + 1);
   localparam int unsigned TERM_W = pnf_pkg::VAL_W + 16;
   localparam int unsigned ACC_W  = TERM_W + $clog2(MAX_OCTAVES) + 2;
   localparam int unsigned PAIRS  = (MAX_OCTAVES + 1) / 2;
   localparam int unsigned R_W    = ACC_W + 9;

   logic signed [ACC_W-1:0] term_in [MAX_OCTAVES];
   logic signed [ACC_W-1:0] pair_ff [PAIRS];
   logic signed [ACC_W-1:0] acc_in;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [ACC_W-1:0] v_in;
   logic [R_W-1:0]          r_in;
   logic [pnf_pkg::NOISE_W-1:0] value_ff;

   always_comb begin
      for (int o = 0; o < MAX_OCTAVES; o++) begin
         term_in[o] = (OCT_W'(o) < oct_eff) ? (ACC_W'(noise[o]) <<< (16 - o)) : '0;
      end
      acc_in = '0;
      for (int p = 0; p < PAIRS; p++) begin
         acc_in = acc_in + pair_ff[p];
      end
      v_in = acc_ff + (ACC_W'(1) <<< 32);
      if (v_in[ACC_W-1]) begin
         v_in = '0;
      end
      r_in = ((R_W'(v_in) << 8) - R_W'(v_in) + (R_W'(1) << 32)) >> 33;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int p = 0; p < PAIRS; p++) begin
            if (2 * p + 1 < MAX_OCTAVES) begin
               pair_ff[p] <= term_in[2*p] + term_in[2*p+1];
            end else begin
               pair_ff[p] <= term_in[2*p];
            end
         end
         acc_ff   <= acc_in;
         value_ff <= (r_in > R_W'(255)) ? 8'd255 : r_in[7:0];
      end
   end

   assign value = value_ff;

endmodule

// ===== hw/rtl/perlin_noise_fbm_pixel.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// perlin_noise_fbm_pixel - fractal 2D gradient noise, one 8-bit value a pixel
//
// channel  dir  tdata / tuser                                  moves
// req_     in   index[7:0] value[15:8] x[31:16] y[47:32]; kind  load or pixel
// rsp_     out  noise_value[7:0]                               result item
// csr_     in   index 0 base_frequency, 1 octave_count         register write
//
// One item a clock while the output is not stalled; a pixel result passes through
// nine register stages, the first loaded at acceptance (multiply, two table
// reads, dots, two lerps, pair sum, total, map). Loads give no result and
// write each octave's table copies in order.
// Synchronous reset clears valid bits and sets the CSR registers to their
// defaults; table copies hold until written. A stalled output freezes every
// stage; the table size must be a power of two.
// ---------------------------------------------------------------------------
module perlin_noise_fbm_pixel #(
   parameter int unsigned TABLE_ENTRIES = pnf_pkg::TABLE_ENTRIES_DEF,
   parameter int unsigned MAX_OCTAVES   = pnf_pkg::MAX_OCTAVES_DEF,
   parameter int unsigned COORD_BITS    = pnf_pkg::COORD_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // table_index, table_value, pixel_x, pixel_y
   input  logic [pnf_pkg::REQ_W-1:0]       req_tdata,
   // kind
   input  logic [0:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // noise_value
   output logic [pnf_pkg::NOISE_W-1:0]     rsp_tdata,
   input  logic                            csr_we,
   input  logic [pnf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pnf_pkg::FREQ_W-1:0]      csr_wdata
);

   localparam int unsigned MUL_W = COORD_BITS + pnf_pkg::FREQ_W;
   localparam int unsigned OCT_W = $clog2(MAX_OCTAVES + 1);

   logic [pnf_pkg::FREQ_W-1:0]    freq_ff;
   logic [pnf_pkg::OCT_CNT_W-1:0] oct_ff;
   logic [OCT_W-1:0]              oct_eff;

   logic adv;
   pnf_pkg::pnf_ctl_type ctl1_ff;
   pnf_pkg::pnf_ctl_type ctl2_ff;
   logic [MUL_W-1:0] mul_x_ff;
   logic [MUL_W-1:0] mul_y_ff;
   logic [5:0]       pv_ff;
   logic             rsp_valid_ff;

   logic [COORD_BITS-1:0] px;
   logic [COORD_BITS-1:0] py;

   pnf_pkg::val_type noise [MAX_OCTAVES];

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = rsp_valid_ff;
   assign px         = COORD_BITS'(req_tdata[31:16]);
   assign py         = COORD_BITS'(req_tdata[47:32]);
   assign oct_eff    = ({1'b0, oct_ff} > 5'(MAX_OCTAVES)) ? OCT_W'(MAX_OCTAVES)
                                                         : OCT_W'(oct_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff <= pnf_pkg::FREQ_RESET;
         oct_ff  <= pnf_pkg::OCT_RESET;
      end else if (csr_we) begin
         unique case (pnf_pkg::csr_index_type'(csr_index))
            pnf_pkg::CSR_BASE_FREQ: freq_ff <= csr_wdata;
            pnf_pkg::CSR_OCT_COUNT: oct_ff  <= csr_wdata[pnf_pkg::OCT_CNT_W-1:0];
            default:                oct_ff  <= oct_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff.valid <= 1'b0;
         ctl2_ff.valid <= 1'b0;
         pv_ff         <= '0;
         rsp_valid_ff  <= 1'b0;
      end else if (adv) begin
         ctl1_ff.valid <= req_tvalid;
         ctl2_ff.valid <= ctl1_ff.valid;
         pv_ff         <= {pv_ff[4:0], ctl2_ff.valid && ctl2_ff.pixel};
         rsp_valid_ff  <= pv_ff[5];
         ctl1_ff.pixel <= req_tuser[0];
         ctl1_ff.index <= req_tdata[7:0];
         ctl1_ff.value <= req_tdata[15:8];
         ctl2_ff.pixel <= ctl1_ff.pixel;
         ctl2_ff.index <= ctl1_ff.index;
         ctl2_ff.value <= ctl1_ff.value;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mul_x_ff      <= MUL_W'(px) * MUL_W'(freq_ff);
         mul_y_ff      <= MUL_W'(py) * MUL_W'(freq_ff);
      end
   end

   for (genvar o = 0; o < MAX_OCTAVES; o++) begin : g_oct
      pnf_octave #(
         .TABLE_ENTRIES (TABLE_ENTRIES),
         .COORD_BITS    (COORD_BITS),
         .OCTAVE        (o)
      ) u_octave (
         .clock (clock),
         .adv   (adv),
         .ctl1  (ctl1_ff),
         .ctl2  (ctl2_ff),
         .mul_x (mul_x_ff),
         .mul_y (mul_y_ff),
         .noise (noise[o])
      );
   end

   pnf_sum #(
      .MAX_OCTAVES (MAX_OCTAVES)
   ) u_sum (
      .clock   (clock),
      .adv     (adv),
      .oct_eff (oct_eff),
      .noise   (noise),
      .value   (rsp_tdata)
   );

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("output valid after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !req_tready |=> $stable(pv_ff) && $stable(ctl1_ff.valid) && $stable(ctl2_ff.valid))
      else $error("pipeline moved during stall");

   a_pixel_out: assert property (@(posedge clock) disable iff (reset)
      adv && pv_ff[5] |=> rsp_tvalid)
      else $error("pixel item lost before output");

endmodule
